FILE: sv/oaht_pkg.sv
// Package for the open addressing hash table: payload types, opcodes, slot codes.
// Used by every module of the block except oaht_ram; depends on nothing.
package oaht_pkg;

    localparam int SLOT_COUNT_DEF = 256;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_SET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_EMPTY     = 2'd0,
        ST_OCCUPIED  = 2'd1,
        ST_TOMBSTONE = 2'd2,
        ST_UNUSED    = 2'd3
    } t_slot_st;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] lookup_key;
        logic [31:0] key_hash;
        logic [63:0] new_value;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_value;
        logic        table_full;
    } t_rsp;

endpackage

FILE: sv/oaht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module oaht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/oaht_front.sv
// Front end: accepts items, reduces the hash to a start slot, queues them.
// Depends on oaht_pkg.
module oaht_front #(
    parameter int SLOT_COUNT = oaht_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  oaht_pkg::t_req                i_req,
    output logic                          o_full,
    output logic                          o_q_valid,
    output oaht_pkg::t_req                o_q_req,
    output logic [$clog2(SLOT_COUNT)-1:0] o_q_start,
    input  logic                          i_q_take
);
    localparam int AW = $clog2(SLOT_COUNT);

    // Hash mod: stage 1 multiplies by a reciprocal, stage 2 corrects.
    localparam int RB = 32 + AW + 1;
    localparam logic [RB:0] RECIP = (RB+1)'((64'd1 << RB) / 64'(SLOT_COUNT));

    logic              r_s1_v;
    logic              r_s1_rdy;
    oaht_pkg::t_req    r_s1_req;
    logic [31:0]       r_s1_q;
    logic              n_s1_take;
    logic [RB+32:0]    w_prod;
    logic [31:0]       w_rem;
    logic [AW-1:0]     w_start;

    // two-entry queue
    logic              r_v0, r_v1;
    oaht_pkg::t_req    r_e0, r_e1;
    logic [AW-1:0]     r_a0, r_a1;

    assign w_prod = (RB+33)'(r_s1_req.key_hash) * (RB+33)'(RECIP);
    assign w_rem  = r_s1_req.key_hash - 32'(r_s1_q * 32'(SLOT_COUNT));
    assign w_start = (w_rem >= 32'(SLOT_COUNT)) ? AW'(w_rem - 32'(SLOT_COUNT)) : AW'(w_rem);

    assign o_full    = r_s1_v;
    assign n_s1_take = r_s1_v && r_s1_rdy && !(r_v1 && !i_q_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s1_rdy <= 1'b0;
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
        end else begin
            // stage 1 holds the item while the quotient estimate settles
            if (i_push && !o_full) begin
                r_s1_v   <= 1'b1;
                r_s1_rdy <= 1'b0;
                r_s1_req <= i_req;
            end else if (r_s1_v && !r_s1_rdy) begin
                r_s1_q   <= 32'(w_prod >> RB);
                r_s1_rdy <= 1'b1;
            end
            if (n_s1_take) begin
                r_s1_v <= 1'b0;
            end
            // queue: pop head, shift, append
            if (i_q_take) begin
                r_v0 <= r_v1;
                r_e0 <= r_e1;
                r_a0 <= r_a1;
                r_v1 <= 1'b0;
            end
            if (n_s1_take) begin
                if (!r_v0 || (i_q_take && !r_v1)) begin
                    r_v0 <= 1'b1;
                    r_e0 <= r_s1_req;
                    r_a0 <= w_start;
                end else begin
                    r_v1 <= 1'b1;
                    r_e1 <= r_s1_req;
                    r_a1 <= w_start;
                end
            end
        end
    end

    assign o_q_valid = r_v0;
    assign o_q_req   = r_e0;
    assign o_q_start = r_a0;
endmodule

FILE: sv/oaht_back.sv
// Back end: probe sequencer over the slot stores and the result register.
// Depends on oaht_pkg and oaht_ram.
module oaht_back #(
    parameter int SLOT_COUNT = oaht_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  oaht_pkg::t_req                i_q_req,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_q_start,
    output logic                          o_q_take,
    output logic                          o_empty,
    output oaht_pkg::t_rsp                o_rsp,
    input  logic                          i_pop
);
    localparam int AW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int LW = CW + 2;
    localparam logic [LW-1:0] LOAD_LIM = LW'(3 * SLOT_COUNT);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE
    } t_state;

    t_state          r_state;
    oaht_pkg::t_req  r_req;
    logic [AW-1:0]   r_idx;
    logic [CW-1:0]   r_n;
    logic            r_have_tomb;
    logic [AW-1:0]   r_tomb;
    logic [CW-1:0]   r_used;
    oaht_pkg::t_rsp  r_res;
    logic            r_out_v;
    oaht_pkg::t_rsp  r_out;

    logic            w_st_we;
    logic [AW-1:0]   w_st_wa;
    logic [1:0]      w_st_wd;
    logic [1:0]      w_st_rd;
    logic            w_kv_we;
    logic [AW-1:0]   w_kv_wa;
    logic [127:0]    w_kv_wd;
    logic [127:0]    w_kv_rd;
    logic [AW-1:0]   w_idx_nx;
    logic            w_over;

    oaht_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_status (
        .i_clk(i_clk), .i_we(w_st_we), .i_waddr(w_st_wa), .i_wdata(w_st_wd),
        .i_raddr(r_idx), .o_rdata(w_st_rd)
    );
    oaht_ram #(.WIDTH(128), .DEPTH(SLOT_COUNT)) u_keyval (
        .i_clk(i_clk), .i_we(w_kv_we), .i_waddr(w_kv_wa), .i_wdata(w_kv_wd),
        .i_raddr(r_idx), .o_rdata(w_kv_rd)
    );

    assign w_idx_nx = (r_idx == AW'(SLOT_COUNT - 1)) ? '0 : r_idx + 1'b1;
    assign w_over   = ({r_used, 2'b00} + LW'(4)) > LOAD_LIM;
    assign o_q_take = (r_state == S_IDLE) && i_q_valid;
    assign o_empty  = !r_out_v;
    assign o_rsp    = r_out;

    // writes happen in S_CLEAR and S_CHECK only
    always_comb begin
        w_st_we = 1'b0;
        w_st_wa = r_idx;
        w_st_wd = oaht_pkg::ST_EMPTY;
        w_kv_we = 1'b0;
        w_kv_wa = r_idx;
        w_kv_wd = {r_req.lookup_key, r_req.new_value};
        if (r_state == S_CLEAR) begin
            w_st_we = 1'b1;
        end else if (r_state == S_CHECK) begin
            if (w_st_rd == oaht_pkg::ST_OCCUPIED && w_kv_rd[127:64] == r_req.lookup_key) begin
                if (r_req.operation == oaht_pkg::OP_SET) begin
                    w_kv_we = 1'b1;
                end else if (r_req.operation == oaht_pkg::OP_DELETE) begin
                    w_st_we = 1'b1;
                    w_st_wd = oaht_pkg::ST_TOMBSTONE;
                end
            end else if ((w_st_rd == oaht_pkg::ST_EMPTY || r_n == CW'(SLOT_COUNT - 1))
                         && r_req.operation == oaht_pkg::OP_SET && !w_over
                         && (w_st_rd == oaht_pkg::ST_EMPTY || r_have_tomb
                             || w_st_rd == oaht_pkg::ST_TOMBSTONE)) begin
                w_st_we = 1'b1;
                w_st_wd = oaht_pkg::ST_OCCUPIED;
                w_kv_we = 1'b1;
                if (r_have_tomb) begin
                    w_st_wa = r_tomb;
                    w_kv_wa = r_tomb;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_used  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= w_idx_nx;
                    if (r_idx == AW'(SLOT_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req       <= i_q_req;
                        r_idx       <= i_q_start;
                        r_n         <= '0;
                        r_have_tomb <= 1'b0;
                        r_res       <= '0;
                        r_state     <= (i_q_req.operation == oaht_pkg::OP_NONE)
                                       ? S_DONE : S_READ;
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    r_state <= S_DONE;
                    if (w_st_rd == oaht_pkg::ST_OCCUPIED
                        && w_kv_rd[127:64] == r_req.lookup_key) begin
                        if (r_req.operation == oaht_pkg::OP_GET) begin
                            r_res.hit        <= 1'b1;
                            r_res.read_value <= w_kv_rd[63:0];
                        end else if (r_req.operation == oaht_pkg::OP_DELETE) begin
                            r_res.hit <= 1'b1;
                        end
                    end else if (w_st_rd == oaht_pkg::ST_EMPTY
                                 || r_n == CW'(SLOT_COUNT - 1)) begin
                        // probe ends: free slot, or whole table visited
                        if (r_req.operation == oaht_pkg::OP_SET) begin
                            if (w_over || (w_st_rd != oaht_pkg::ST_EMPTY && !r_have_tomb
                                           && w_st_rd != oaht_pkg::ST_TOMBSTONE)) begin
                                r_res.table_full <= 1'b1;
                            end else begin
                                r_res.hit <= 1'b1;
                                if (w_st_rd == oaht_pkg::ST_EMPTY && !r_have_tomb) begin
                                    r_used <= r_used + 1'b1;
                                end
                            end
                        end
                    end else begin
                        if (w_st_rd == oaht_pkg::ST_TOMBSTONE && !r_have_tomb) begin
                            r_have_tomb <= 1'b1;
                            r_tomb      <= r_idx;
                        end
                        r_idx   <= w_idx_nx;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_v || i_pop) begin
                        r_out   <= r_res;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/open_addressing_hash_table_core.sv
// Open addressing hash table, linear probing with tombstones: top level.
// An item passes through the front end (reciprocal hash reduction, then the
// queue write), is taken by the back end, gets a status/key RAM read and then
// a compare for each probed slot, and ends with the result hand-off. The back
// end takes a new item only once the last one has handed off its result, and
// the probe loop through the slot RAMs sets the rate; the front end takes no
// new item while its stage 1 holds one, and a waiting result stalls the back end.
// After reset a clearing pass walks every slot and empties the status store;
// items queue but are not processed until it ends.
// Depends on oaht_pkg, oaht_front, oaht_back.
module open_addressing_hash_table_core #(
    parameter int SLOT_COUNT = oaht_pkg::SLOT_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  oaht_pkg::t_req i_req,
    output logic           empty,
    input  logic           pop,
    output oaht_pkg::t_rsp o_rsp
);
    logic                          w_q_valid;
    oaht_pkg::t_req                w_q_req;
    logic [$clog2(SLOT_COUNT)-1:0] w_q_start;
    logic                          w_q_take;

    oaht_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_req(i_req),
        .o_full(full), .o_q_valid(w_q_valid), .o_q_req(w_q_req),
        .o_q_start(w_q_start), .i_q_take(w_q_take)
    );

    oaht_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_q_valid),
        .i_q_req(w_q_req), .i_q_start(w_q_start), .o_q_take(w_q_take),
        .o_empty(empty), .o_rsp(o_rsp), .i_pop(pop)
    );
endmodule

FILE: sv/oaht_checker.sv
// Port-level checks for the hash table core, bound to the top level.
// Depends on oaht_pkg.
module oaht_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input oaht_pkg::t_rsp o_rsp
);
    // a result never both adds a key and reports the table full
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_rsp.hit && o_rsp.table_full)) else $error("hit with full");
    // a value is only read back on a hit
    a_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_rsp.hit) |-> o_rsp.read_value == 64'd0) else $error("stray value");
    // a waiting result holds while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rsp))) else $error("result lost");
    // nothing comes out and nothing is held right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full)) else $error("result after reset");
endmodule

bind open_addressing_hash_table_core oaht_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full),
    .empty(empty), .pop(pop), .o_rsp(o_rsp)
);

FILE: test/open_addressing_hash_table_core_tb.sv
// Testbench for the open addressing hash table core: drives get/set/delete/no-op items
// through the push/full queue and checks every result against a local table model.
// Depends on oaht_pkg and open_addressing_hash_table_core.
`timescale 1ns / 1ps

module open_addressing_hash_table_core_tb;

    localparam int SLOTS = 256;
    localparam int CYCLE_LIMIT = 10000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    oaht_pkg::t_req i_req = '0;
    logic empty;
    logic pop = 1'b0;
    oaht_pkg::t_rsp o_rsp;

    open_addressing_hash_table_core #(.SLOT_COUNT(SLOTS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_req(i_req),
        .empty(empty), .pop(pop), .o_rsp(o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table model
    oaht_pkg::t_slot_st tbl_st [SLOTS];
    logic [63:0]        tbl_key[SLOTS];
    logic [63:0]        tbl_val[SLOTS];
    int                 tbl_used;
    oaht_pkg::t_rsp     rsp_due[$];
    int                 n_bad = 0;
    int                 n_cycles = 0;
    bit                 hold_rx = 1'b0;
    logic [63:0]        live_keys[$];

    // Mirror one operation in the table model and return the response it gives.
    function automatic oaht_pkg::t_rsp table_apply(oaht_pkg::t_req r);
        oaht_pkg::t_rsp res = '0;
        int idx, tomb, where, n;
        bit found, free_hit;
        idx = r.key_hash % SLOTS;
        tomb = -1; found = 0; free_hit = 0; where = 0;
        for (n = 0; n < SLOTS; n++) begin
            if (tbl_st[idx] == oaht_pkg::ST_EMPTY) begin
                where = (tomb >= 0) ? tomb : idx;
                free_hit = 1;
                break;
            end else if (tbl_st[idx] == oaht_pkg::ST_TOMBSTONE) begin
                if (tomb < 0) tomb = idx;
            end else if (tbl_key[idx] == r.lookup_key) begin
                where = idx;
                found = 1;
                break;
            end
            idx = (idx + 1) % SLOTS;
        end
        if (!found && !free_hit && tomb >= 0) begin
            where = tomb;
            free_hit = 1;
        end
        case (oaht_pkg::t_op'(r.operation))
            oaht_pkg::OP_GET: begin
                if (found) begin
                    res.hit = 1'b1;
                    res.read_value = tbl_val[where];
                end
            end
            oaht_pkg::OP_SET: begin
                if (found) begin
                    tbl_val[where] = r.new_value;
                end else if (4 * (tbl_used + 1) > 3 * SLOTS || !free_hit) begin
                    res.table_full = 1'b1;
                end else begin
                    if (tbl_st[where] == oaht_pkg::ST_EMPTY) tbl_used++;
                    tbl_st[where] = oaht_pkg::ST_OCCUPIED;
                    tbl_key[where] = r.lookup_key;
                    tbl_val[where] = r.new_value;
                    res.hit = 1'b1;
                end
            end
            oaht_pkg::OP_DELETE: begin
                if (found) begin
                    tbl_st[where] = oaht_pkg::ST_TOMBSTONE;
                    res.hit = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_item(oaht_pkg::t_req r);
        push <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        rsp_due.push_back(table_apply(r));
        if (r.operation == oaht_pkg::OP_SET && !rsp_due[$].table_full && rsp_due[$].hit)
            live_keys.push_back(r.lookup_key);
        // drop the valid only if the next item is not sent straight away
        if ($urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic oaht_pkg::t_req make_item(int op, logic [63:0] key,
                                                 logic [31:0] hash, logic [63:0] val);
        oaht_pkg::t_req r;
        r.operation = op[1:0];
        r.lookup_key = key;
        r.key_hash = hash;
        r.new_value = val;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Key drawn from a small pool so that hits, collisions and reuse are common;
    // the hash follows the key so that equal keys probe from one start slot.
    function automatic oaht_pkg::t_req pooled_item(int op, int pool);
        logic [63:0] key;
        if (live_keys.size() > 0 && $urandom_range(0, 1))
            key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else
            key = {32'hA5A5_0000 ^ $urandom_range(0, 3), 32'($urandom_range(0, pool))};
        return make_item(op, key,
                         {key[39:32], key[23:0]} ^ 32'(key[63:40]) ^ 32'(key[7:0] * 8'd3),
                         rand64());
    endfunction

    // Drop the valid first so the last item is not offered a second time.
    task automatic wait_drained();
        push <= 1'b0;
        while (rsp_due.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [63:0] k0 = 64'hFFFF_FFFF_FFFF_FFFF;
        send_item(make_item(oaht_pkg::OP_GET, k0, 32'hFFFF_FFFF, '0));
        send_item(make_item(oaht_pkg::OP_SET, k0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_item(make_item(oaht_pkg::OP_GET, k0, 32'hFFFF_FFFF, '0));
        send_item(make_item(oaht_pkg::OP_SET, k0, 32'hFFFF_FFFF, 64'h0));
        send_item(make_item(oaht_pkg::OP_GET, k0, 32'hFFFF_FFFF, '1));
        send_item(make_item(oaht_pkg::OP_SET, 64'h0, 32'h0, 64'h1234));
        // collide on the last slot so the probe wraps to slot 0 and beyond
        send_item(make_item(oaht_pkg::OP_SET, 64'h5, 32'h0000_00FF, 64'h55));
        send_item(make_item(oaht_pkg::OP_GET, 64'h5, 32'h0000_00FF, '0));
        send_item(make_item(oaht_pkg::OP_DELETE, k0, 32'hFFFF_FFFF, '1));
        send_item(make_item(oaht_pkg::OP_DELETE, k0, 32'hFFFF_FFFF, '0));
        send_item(make_item(oaht_pkg::OP_GET, 64'h5, 32'h0000_00FF, '0));
        // reuse the tombstone
        send_item(make_item(oaht_pkg::OP_SET, 64'h6, 32'h1234_56FF, 64'h66));
        send_item(make_item(oaht_pkg::OP_GET, 64'h6, 32'hFFFF_FFFF, '0));
        send_item(make_item(oaht_pkg::OP_NONE, 64'h6, 32'hFFFF_FFFF, '1));
        send_item(make_item(oaht_pkg::OP_GET, 64'h0, 32'h0, '0));
        wait_drained();
    endtask

    // Fill past the load limit, check rejects and an update; deletes keep the load.
    task automatic test_load_limit();
        int i;
        for (i = 0; i < 200; i++)
            send_item(make_item(oaht_pkg::OP_SET, {32'hC0DE_0000, 32'(i)}, $urandom,
                                rand64()));
        send_item(make_item(oaht_pkg::OP_SET, {32'hC0DE_0000, 32'd3}, $urandom, rand64()));
        for (i = 0; i < 20; i++)
            send_item(make_item(oaht_pkg::OP_DELETE, {32'hC0DE_0000, 32'(i)}, $urandom, '0));
        send_item(make_item(oaht_pkg::OP_SET, 64'hBEEF, $urandom, rand64()));
        wait_drained();
    endtask

    task automatic test_random(int count, int pool);
        int i, op, sel;
        for (i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            op = (sel < 8) ? oaht_pkg::OP_SET : (sel < 14) ? oaht_pkg::OP_GET :
                 (sel < 19) ? oaht_pkg::OP_DELETE : oaht_pkg::OP_NONE;
            if ($urandom_range(0, 15) == 0)
                send_item(make_item(op, rand64(), $urandom, rand64()));
            else
                send_item(pooled_item(op, pool));
        end
        wait_drained();
    endtask

    // Receiver holds off a long stretch while items keep arriving.
    task automatic test_backpressure();
        int i;
        hold_rx = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (i = 0; i < 60; i++) send_item(pooled_item(oaht_pkg::OP_GET, 400));
        join
        wait_drained();
    endtask

    // Receiver: stall pattern of its own.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_rx) pop <= 1'b0;
        else if (n_cycles % 300 < 100) pop <= 1'b1;
        else pop <= ($urandom_range(0, 2) != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (rsp_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %p", o_rsp);
            end else begin
                if (o_rsp.hit !== rsp_due[0].hit || o_rsp.read_value !== rsp_due[0].read_value
                    || o_rsp.table_full !== rsp_due[0].table_full) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected %p, got %p", rsp_due[0], o_rsp);
                end
                void'(rsp_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("[open_addressing_hash_table_core] ERROR");
            $finish;
        end
    end

    initial begin
        int i;
        tbl_used = 0;
        for (i = 0; i < SLOTS; i++) begin
            tbl_st[i] = oaht_pkg::ST_EMPTY;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(700, 60);
        test_load_limit();
        test_random(950, 400);
        repeat (50) @(posedge i_clk);
        if (n_bad == 0 && rsp_due.size() == 0)
            $display("[open_addressing_hash_table_core] OK");
        else
            $display("[open_addressing_hash_table_core] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/oaht_pkg.sv
sv/oaht_ram.sv
sv/oaht_front.sv
sv/oaht_back.sv
sv/open_addressing_hash_table_core.sv
sv/oaht_checker.sv
test/open_addressing_hash_table_core_tb.sv
